// File: hw/rtl/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared constants and helpers for the integer to ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2a_pkg;

    localparam int unsigned CMD_W   = 2;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CH_W    = 8;

    // format selector codes
    localparam logic [CMD_W-1:0] CMD_SDEC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UDEC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_HEX  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;

    localparam logic [CH_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CHAR_ALPHA = 8'h57;    // 0x60 - 9
    localparam logic [CH_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CH_W-1:0] CHAR_X     = 8'h78;

    // ceil(2^35 / 10): floor(x * RECIP10 / 2^35) == x / 10 for any 32-bit x
    localparam logic [VALUE_W-1:0] RECIP10   = 32'hcccc_cccd;
    localparam int unsigned        RECIP_SH  = 35;
    localparam int unsigned        QUOT_W    = 2 * VALUE_W - RECIP_SH;

    localparam int unsigned DIG_DEPTH = 10;
    localparam int unsigned DIG_AW    = $clog2(DIG_DEPTH);

    function automatic logic [CH_W-1:0] dig2char(input logic [3:0] d);
        logic [CH_W-1:0] c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + {4'b0, d};
        end
        else
        begin
            c = CHAR_ALPHA + {4'b0, d};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/i2a_item_if.sv
// ----------------------------------------------------------------------------
// i2a_item_if
// Input channel: format selector and 32-bit value, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2a_item_if import i2a_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/i2a_text_if.sv
// ----------------------------------------------------------------------------
// i2a_text_if
// Output channel: one ASCII character per item plus last marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2a_text_if import i2a_pkg::*;;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/integer_to_ascii_converter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_converter
// Converts a 32-bit value to signed decimal, unsigned decimal or hex text,
// one character per output item, most significant character first.
// ----------------------------------------------------------------------------
// Sequence: decimal runs a multiply step on the shared reciprocal
//   multiplier, then a remainder step, per digit, for up to 10 digits;
//   hex runs one step per nibble plus a final one. Characters then leave
//   one per cycle while the output is ready, up to 11. A new item is
//   accepted only in idle, after the last character of the previous one.
// Reset: asynchronous, clears all registers but the digit buffer.
`default_nettype none

module integer_to_ascii_converter import i2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    i2a_item_if.sink    data,
    i2a_text_if.source  text
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_HEX,
        S_EMIT
    } state_t;

    state_t               state_reg;
    logic [VALUE_W-1:0]   mag_reg;
    logic [QUOT_W-1:0]    q_reg;
    logic [DIG_AW-1:0]    dcnt_reg;
    logic [1:0]           pre_left_reg;
    logic                 hex_reg;
    logic                 oval_reg;
    logic [CH_W-1:0]      ch_reg;
    logic                 last_reg;

    logic [3:0]           dbuf_reg [DIG_DEPTH];

    logic                 neg_w;
    logic [VALUE_W-1:0]   mag_in_w;
    logic [2*VALUE_W-1:0] prod_w;
    logic [VALUE_W-1:0]   q10_w;
    logic [VALUE_W-1:0]   rem_w;
    logic                 slot_free_w;
    logic [CH_W-1:0]      cur_ch_w;
    logic                 cur_last_w;
    logic                 dbuf_we;
    logic [DIG_AW-1:0]    dbuf_wa;
    logic [3:0]           dbuf_wd;

    assign data.ready = (state_reg == S_IDLE);
    assign text.valid = oval_reg;
    assign text.ch    = ch_reg;
    assign text.last  = last_reg;

    assign neg_w    = (data.cmd == CMD_SDEC) && data.value[VALUE_W-1];
    assign mag_in_w = neg_w ? (VALUE_W'(0) - data.value) : data.value;

    assign prod_w = {{VALUE_W{1'b0}}, mag_reg} * {{VALUE_W{1'b0}}, RECIP10};
    assign q10_w  = {q_reg, 3'b000} + {2'b00, q_reg, 1'b0};
    assign rem_w  = mag_reg - q10_w;

    assign slot_free_w = !oval_reg || text.ready;

    always_comb
    begin
        if (pre_left_reg != 2'd0)
        begin
            if (hex_reg)
            begin
                cur_ch_w = (pre_left_reg == 2'd2) ? CHAR_X : CHAR_ZERO;
            end
            else
            begin
                cur_ch_w = CHAR_MINUS;
            end
        end
        else
        begin
            cur_ch_w = dig2char(dbuf_reg[dcnt_reg - DIG_AW'(1)]);
        end
        cur_last_w = ((pre_left_reg == 2'd1) && (dcnt_reg == DIG_AW'(0)))
                  || ((pre_left_reg == 2'd0) && (dcnt_reg == DIG_AW'(1)));
    end

    always_comb
    begin
        dbuf_we = 1'b0;
        dbuf_wa = dcnt_reg;
        dbuf_wd = rem_w[3:0];
        unique case (state_reg)
            S_IDLE:
            begin
                dbuf_wa = DIG_AW'(0);
                dbuf_wd = 4'd0;
                dbuf_we = data.valid && (data.cmd == CMD_SDEC || data.cmd == CMD_UDEC)
                       && (mag_in_w == VALUE_W'(0));
            end
            S_DIV:
            begin
                dbuf_we = 1'b1;
            end
            S_HEX:
            begin
                dbuf_wd = mag_reg[3:0];
                dbuf_we = (mag_reg != VALUE_W'(0));
            end
            default:
            begin
                dbuf_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dbuf_we)
        begin
            dbuf_reg[dbuf_wa] <= dbuf_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mag_reg      <= '0;
            q_reg        <= '0;
            dcnt_reg     <= '0;
            pre_left_reg <= '0;
            hex_reg      <= 1'b0;
            oval_reg     <= 1'b0;
            ch_reg       <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            if (oval_reg && text.ready && (state_reg != S_EMIT))
            begin
                oval_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (data.valid)
                    begin
                        unique case (data.cmd)
                            CMD_SDEC, CMD_UDEC:
                            begin
                                mag_reg      <= mag_in_w;
                                hex_reg      <= 1'b0;
                                pre_left_reg <= neg_w ? 2'd1 : 2'd0;
                                if (mag_in_w == VALUE_W'(0))
                                begin
                                    dcnt_reg  <= DIG_AW'(1);
                                    state_reg <= S_EMIT;
                                end
                                else
                                begin
                                    dcnt_reg  <= DIG_AW'(0);
                                    state_reg <= S_MUL;
                                end
                            end
                            CMD_HEX:
                            begin
                                mag_reg      <= data.value;
                                hex_reg      <= 1'b1;
                                pre_left_reg <= 2'd3;
                                dcnt_reg     <= DIG_AW'(0);
                                state_reg    <= S_HEX;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_MUL:
                begin
                    q_reg     <= prod_w[2*VALUE_W-1:RECIP_SH];
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    mag_reg  <= {{(VALUE_W-QUOT_W){1'b0}}, q_reg};
                    dcnt_reg <= dcnt_reg + DIG_AW'(1);
                    if (q_reg == QUOT_W'(0))
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_HEX:
                begin
                    if (mag_reg == VALUE_W'(0))
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        mag_reg  <= mag_reg >> 4;
                        dcnt_reg <= dcnt_reg + DIG_AW'(1);
                    end
                end
                S_EMIT:
                begin
                    if (slot_free_w)
                    begin
                        oval_reg <= 1'b1;
                        ch_reg   <= cur_ch_w;
                        last_reg <= cur_last_w;
                        if (pre_left_reg != 2'd0)
                        begin
                            pre_left_reg <= pre_left_reg - 2'd1;
                        end
                        else
                        begin
                            dcnt_reg <= dcnt_reg - DIG_AW'(1);
                        end
                        if (cur_last_w)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_dcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= DIG_AW'(DIG_DEPTH))
        else $error("digit count out of range");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (dcnt_reg != DIG_AW'(0) || pre_left_reg != 2'd0))
        else $error("emit with nothing left");

    a_rsvd_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (data.valid && data.ready && data.cmd == CMD_RSVD) |=> (state_reg == S_IDLE))
        else $error("reserved item not dropped");

    a_rem_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_w < VALUE_W'(10)))
        else $error("decimal remainder out of range");
`endif

endmodule

`default_nettype wire
